### rtl/core/xrh_pkg.sv
// shared types, constants and functions of the four-lane xor-rotate hash
package xrh_pkg;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    localparam logic [63:0] K_GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K_M1   = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] K_M2   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] K_M3   = 64'h94D049BB133111EB;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        is_seed;
        logic        last;
        logic [1:0]  lane;
        logic [2:0]  nbytes;
        logic        mix;
        logic [31:0] len;
        logic [63:0] data;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
        return (x << k) | (x >> (64 - k));
    endfunction

    function automatic logic [63:0] lane_rotate(input logic [63:0] x, input logic [1:0] lane);
        logic [63:0] r;
        unique case (lane)
            2'd0:    r = rotl64(x, 11);
            2'd1:    r = rotl64(x, 17);
            2'd2:    r = rotl64(x, 23);
            default: r = rotl64(x, 57);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] seed_const(input logic [1:0] idx);
        logic [63:0] r;
        unique case (idx)
            2'd0:    r = K_GOLD;
            2'd1:    r = K_M1;
            2'd2:    r = K_M2;
            default: r = K_M3;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/xrh_if.sv
// request and result channel interfaces of the hash unit
interface xrh_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] seed;
    logic [31:0] message_length;
    logic [63:0] data_word;

    modport source (output valid, func, seed, message_length, data_word, input ready);
    modport sink   (input valid, func, seed, message_length, data_word, output ready);
endinterface

interface xrh_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (output valid, digest, input ready);
    modport sink   (input valid, digest, output ready);
endinterface

### rtl/core/xrh_front.sv
// request front end: tracks byte count and block position, classifies each request
module xrh_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xrh_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output xrh_pkg::t_cmd o_cmd
);

    localparam int LenW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    logic            r_active, n_active;
    logic [LenW-1:0] r_bl, n_bl;
    logic [1:0]      r_pos, n_pos;
    logic            r_parity, n_parity;

    logic            accept;
    logic [LenW-1:0] len_in;
    logic            tail;
    logic            short;
    logic            wrap;
    logic [LenW-1:0] data_bl;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign len_in      = i_req.message_length[LenW-1:0];

    assign tail    = (r_pos == 2'd0) && (r_bl < LenW'(32));
    assign short   = tail && (r_bl < LenW'(8));
    assign wrap    = !tail && (r_pos == 2'd3);
    assign data_bl = short ? '0 : (r_bl - LenW'(8));

    always_comb begin
        n_active = r_active;
        n_bl     = r_bl;
        n_pos    = r_pos;
        n_parity = r_parity;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            if (i_req.func == xrh_pkg::FUNC_START) begin
                o_push        = 1'b1;
                o_cmd.is_seed = 1'b1;
                o_cmd.last    = (len_in == '0);
                o_cmd.len     = 32'(len_in);
                o_cmd.data    = i_req.seed;
                n_active      = (len_in != '0);
                n_bl          = len_in;
                n_pos         = 2'd0;
                n_parity      = 1'b0;
            end else if (r_active) begin
                o_push       = 1'b1;
                o_cmd.lane   = tail ? 2'd0 : r_pos;
                o_cmd.nbytes = short ? r_bl[2:0] : 3'd0;
                o_cmd.mix    = wrap && r_parity;
                o_cmd.last   = (data_bl == '0);
                o_cmd.data   = i_req.data_word;
                n_bl         = data_bl;
                n_active     = (data_bl != '0);
                n_pos        = tail ? r_pos : r_pos + 2'd1;
                n_parity     = wrap ? !r_parity : r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_bl     <= '0;
            r_pos    <= 2'd0;
            r_parity <= 1'b0;
        end else begin
            r_active <= n_active;
            r_bl     <= n_bl;
            r_pos    <= n_pos;
            r_parity <= n_parity;
        end
    end

endmodule

### rtl/core/xrh_queue.sv
// short command queue between front end and lane engine
module xrh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xrh_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_vld,
    output logic          o_full,
    output xrh_pkg::t_cmd o_cmd
);

    xrh_pkg::t_cmd                 r_mem [xrh_pkg::QDEPTH];
    logic [xrh_pkg::QAW-1:0]       r_wp;
    logic [xrh_pkg::QAW-1:0]       r_rp;
    logic [xrh_pkg::QCW-1:0]       r_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == xrh_pkg::QCW'(xrh_pkg::QDEPTH));
    assign o_cmd  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == xrh_pkg::QAW'(xrh_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == xrh_pkg::QAW'(xrh_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_vld))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a request");

endmodule

### rtl/core/xrh_mul.sv
// 64x64 low-half multiplier, one 32x32 partial product per cycle
module xrh_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xrh_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [63:0]       o_p
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb begin
        unique case (r_cnt)
            2'd0: begin
                op_x = r_a[31:0];
                op_y = r_b[31:0];
            end
            2'd1: begin
                op_x = r_a[63:32];
                op_y = r_b[31:0];
            end
            default: begin
                op_x = r_a[31:0];
                op_y = r_b[63:32];
            end
        endcase
    end

    assign prod   = op_x * op_y;
    assign o_done = r_done;
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            if (r_cnt == 2'd0) begin
                r_acc <= prod;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + prod[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 2'd1;
            r_done <= (r_cnt == 2'd2);
            r_busy <= (r_cnt != 2'd2);
        end else begin
            r_done <= 1'b0;
        end
    end

endmodule

### rtl/core/xrh_back.sv
// lane engine: seeding, absorb and cross-mix, fold and finaliser, result register
module xrh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    input  xrh_pkg::t_cmd i_cmd,
    output logic          o_pop,
    xrh_res_if.source     o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEED = 5'b00010,
        S_FOLD = 5'b00100,
        S_FIN  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [63:0]       r_lane [4];
    logic [63:0]       n_lane [4];
    logic [63:0]       r_h, n_h;
    logic              r_last, n_last;
    logic [2:0]        r_idx, n_idx;
    logic [1:0]        r_fidx, n_fidx;
    logic              r_out_vld, n_out_vld;
    logic [63:0]       r_dig, n_dig;

    xrh_pkg::t_mul_req mul_req;
    logic              mul_done;
    logic [63:0]       mul_p;
    logic [63:0]       word;
    logic [63:0]       ab [4];
    logic [63:0]       fold;
    logic [63:0]       base;
    logic [2:0]        idx_m1;

    xrh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign o_res.valid  = r_out_vld;
    assign o_res.digest = r_dig;

    // masked word and single-lane absorb
    always_comb begin
        if (i_cmd.nbytes == 3'd0) begin
            word = i_cmd.data;
        end else begin
            word = i_cmd.data & ~(64'hFFFF_FFFF_FFFF_FFFF << {i_cmd.nbytes, 3'b000});
        end
        for (int i = 0; i < 4; i++) begin
            if (i_cmd.lane == 2'(i)) begin
                ab[i] = xrh_pkg::lane_rotate(r_lane[i] ^ word, 2'(i));
            end else begin
                ab[i] = r_lane[i];
            end
        end
    end

    assign fold   = r_lane[0] ^ r_lane[1] ^ r_lane[2] ^ r_lane[3];
    assign base   = r_h ^ mul_p;
    assign idx_m1 = r_idx - 3'd1;

    always_comb begin
        n_state   = r_state;
        n_lane    = r_lane;
        n_h       = r_h;
        n_last    = r_last;
        n_idx     = r_idx;
        n_fidx    = r_fidx;
        n_dig     = r_dig;
        n_out_vld = r_out_vld && !o_res.ready;
        mul_req   = '0;
        o_pop     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_seed) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = 64'(i_cmd.len);
                        mul_req.b     = xrh_pkg::K_GOLD;
                        n_h           = i_cmd.data;
                        n_last        = i_cmd.last;
                        n_idx         = 3'd0;
                        n_state       = S_SEED;
                    end else begin
                        if (i_cmd.mix) begin
                            n_lane[0] = ab[0] ^ xrh_pkg::rotl64(ab[2], 31);
                            n_lane[2] = ab[2] ^ xrh_pkg::rotl64(ab[0], 37);
                            n_lane[1] = ab[1] ^ xrh_pkg::rotl64(ab[3], 43);
                            n_lane[3] = ab[3] ^ xrh_pkg::rotl64(ab[1], 53);
                        end else begin
                            n_lane = ab;
                        end
                        if (i_cmd.last) begin
                            n_state = S_FOLD;
                        end
                    end
                end
            end
            S_SEED: begin
                if (mul_done) begin
                    if (r_idx == 3'd0) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = base;
                        mul_req.b     = xrh_pkg::seed_const(2'd0);
                        n_h           = base;
                        n_idx         = 3'd1;
                    end else begin
                        n_lane[idx_m1[1:0]] = mul_p;
                        if (r_idx != 3'd4) begin
                            mul_req.start = 1'b1;
                            mul_req.a     = r_h;
                            mul_req.b     = xrh_pkg::seed_const(r_idx[1:0]);
                            n_idx         = r_idx + 3'd1;
                        end else begin
                            n_state = r_last ? S_FOLD : S_IDLE;
                        end
                    end
                end
            end
            S_FOLD: begin
                mul_req.start = 1'b1;
                mul_req.a     = fold ^ (fold >> 29);
                mul_req.b     = xrh_pkg::K_M1;
                n_fidx        = 2'd0;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (mul_done) begin
                    unique case (r_fidx)
                        2'd0: begin
                            mul_req.start = 1'b1;
                            mul_req.a     = mul_p ^ (mul_p >> 31);
                            mul_req.b     = xrh_pkg::K_M2;
                            n_fidx        = 2'd1;
                        end
                        2'd1: begin
                            mul_req.start = 1'b1;
                            mul_req.a     = mul_p ^ (mul_p >> 37);
                            mul_req.b     = xrh_pkg::K_GOLD;
                            n_fidx        = 2'd2;
                        end
                        default: begin
                            n_h     = mul_p ^ (mul_p >> 41);
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld = 1'b1;
                    n_dig     = r_h;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_idx  <= n_idx;
        r_fidx <= n_fidx;
        r_last <= n_last;
        r_dig  <= n_dig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_lane[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_lane    <= n_lane;
        end
    end

endmodule

### rtl/core/xor_rotate_mixed_lane_hash64_unit.sv
// top level of the four-lane xor-rotate hash with 64-bit digest
// throughput: one data request per cycle while the engine is idle; absorb occurs on queue pop
// a start request runs five 64-bit multiplies on the shared 32x32 multiplier
// the finaliser (fold plus three multiplies) runs before the digest appears
// an empty message goes from seeding straight to the finaliser
// synchronous active-low reset empties the queue, drops any message and clears the lanes
module xor_rotate_mixed_lane_hash64_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xrh_req_if.sink   i_req,
    xrh_res_if.source o_res
);

    logic          push;
    logic          pop;
    logic          q_vld;
    logic          q_full;
    xrh_pkg::t_cmd f_cmd;
    xrh_pkg::t_cmd q_cmd;

    xrh_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    xrh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    xrh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### tb/sv/tb.sv
// self-checking bench for the four-lane xor-rotate hash unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_START = xrh_pkg::FUNC_START;
    localparam logic FUNC_DATA  = xrh_pkg::FUNC_DATA;

    localparam int LEN_BITS     = 32;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [31:0] LEN_MASK = (LEN_BITS >= 32) ? 32'hFFFF_FFFF
                                                        : ((32'd1 << LEN_BITS) - 32'd1);

    localparam logic [63:0] MUL_GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MUL_A    = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MUL_B    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MUL_C    = 64'h94D049BB133111EB;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_SILENT,
        ROW_FIXED
    } t_row_kind;

    typedef struct packed {
        logic        func;
        logic [63:0] seed;
        logic [31:0] len;
        logic [63:0] word;
        t_row_kind   kind;
        logic [63:0] want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xrh_req_if req_ch ();
    xrh_res_if res_ch ();

    xor_rotate_mixed_lane_hash64_unit #(
        .LENGTH_BITS(LEN_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // running hash state
    logic [63:0] lane_st [4];
    logic [31:0] left_st;
    logic [1:0]  pos_st;
    logic        parity_st;
    logic        busy_st;

    logic [63:0] digest_q [$];
    logic [63:0] want_dig;
    t_stim_row   dir_tab [$];

    int n_err     = 0;
    int n_items   = 0;
    int n_starts  = 0;
    int n_digests = 0;
    int cyc       = 0;
    bit tail_on   = 1'b0;

    function automatic logic [63:0] rol(input logic [63:0] x, input int k);
        logic [127:0] d;
        d = {x, x} << k;
        return d[127:64];
    endfunction

    function automatic int lane_rot_amt(input logic [1:0] k);
        case (k)
            2'd0:    return 11;
            2'd1:    return 17;
            2'd2:    return 23;
            default: return 57;
        endcase
    endfunction

    function automatic logic [63:0] fold_finish();
        logic [63:0] h;
        h = lane_st[0] ^ lane_st[1] ^ lane_st[2] ^ lane_st[3];
        h = h ^ (h >> 29);
        h = h * MUL_A;
        h = h ^ (h >> 31);
        h = h * MUL_B;
        h = h ^ (h >> 37);
        h = h * MUL_GOLD;
        h = h ^ (h >> 41);
        return h;
    endfunction

    function automatic bit quiet_spell();
        return tail_on || ((cyc / 256) % 4 == 3);
    endfunction

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic flag(input string msg);
        n_err++;
        $display("tb: mismatch at cycle %0d: %s", cyc, msg);
    endtask

    task automatic hash_model(input logic f, input logic [63:0] sd, input logic [31:0] ln,
                              input logic [63:0] w, output bit done, output logic [63:0] dig);
        logic [31:0] len_used;
        logic [63:0] base;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] wm;
        int k;
        done = 1'b0;
        dig  = '0;
        len_used = ln & LEN_MASK;
        wm = w;
        if (f == FUNC_START) begin
            base = sd ^ ({32'd0, len_used} * MUL_GOLD);
            lane_st[0] = base * MUL_GOLD;
            lane_st[1] = base * MUL_A;
            lane_st[2] = base * MUL_B;
            lane_st[3] = base * MUL_C;
            left_st   = len_used;
            pos_st    = 2'd0;
            parity_st = 1'b0;
            busy_st   = (len_used != 32'd0);
            if (len_used == 32'd0) begin
                done = 1'b1;
                dig  = fold_finish();
            end
        end else if (busy_st) begin
            if (pos_st == 2'd0 && left_st < 32) begin
                if (left_st < 8) begin
                    wm = wm & ((64'd1 << (left_st * 8)) - 64'd1);
                    left_st = 32'd0;
                end else begin
                    left_st = left_st - 32'd8;
                end
                lane_st[0] = rol(lane_st[0] ^ wm, 11);
            end else begin
                k = pos_st;
                lane_st[k] = rol(lane_st[k] ^ wm, lane_rot_amt(pos_st));
                left_st = left_st - 32'd8;
                pos_st  = pos_st + 2'd1;
                if (pos_st == 2'd0) begin
                    parity_st = ~parity_st;
                    if (!parity_st) begin
                        a = lane_st[0];
                        b = lane_st[1];
                        lane_st[0] = lane_st[0] ^ rol(lane_st[2], 31);
                        lane_st[2] = lane_st[2] ^ rol(a, 37);
                        lane_st[1] = lane_st[1] ^ rol(lane_st[3], 43);
                        lane_st[3] = lane_st[3] ^ rol(b, 53);
                    end
                end
            end
            if (left_st == 32'd0) begin
                busy_st = 1'b0;
                done    = 1'b1;
                dig     = fold_finish();
            end
        end
    endtask

    task automatic put_req(input logic f, input logic [63:0] sd, input logic [31:0] ln,
                           input logic [63:0] w, input t_row_kind kind,
                           input logic [63:0] fixed);
        bit done;
        bit counts;
        logic [63:0] dig;
        req_ch.valid          <= 1'b1;
        req_ch.func           <= f;
        req_ch.seed           <= sd;
        req_ch.message_length <= ln;
        req_ch.data_word      <= w;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        counts = (f == FUNC_START) || busy_st;
        hash_model(f, sd, ln, w, done, dig);
        if (counts) n_items++;
        if (f == FUNC_START) n_starts++;
        case (kind)
            ROW_FIXED: digest_q.push_back(fixed);
            ROW_MODEL: if (done) digest_q.push_back(dig);
            default: ;
        endcase
    endtask

    task automatic maybe_gap();
        if (!quiet_spell() && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stall bursts
    initial begin : rx_side
        int rx_hold;
        rx_hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                res_ch.ready <= 1'b0;
            end else if (!quiet_spell() && $urandom_range(0, 5) == 0) begin
                rx_hold = $urandom_range(0, 12);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (digest_q.size() == 0) begin
                flag($sformatf("digest %h with none outstanding", res_ch.digest));
            end else begin
                want_dig = digest_q.pop_front();
                n_digests++;
                if (res_ch.digest !== want_dig)
                    flag($sformatf("digest %h, want %h", res_ch.digest, want_dig));
            end
        end
    end

    initial begin : stim
        int base_items;
        int pick;
        int nw;
        logic [31:0] ln;

        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= FUNC_START;
        req_ch.seed           <= '0;
        req_ch.message_length <= '0;
        req_ch.data_word      <= '0;

        lane_st[0] = '0;
        lane_st[1] = '0;
        lane_st[2] = '0;
        lane_st[3] = '0;
        left_st    = '0;
        pos_st     = '0;
        parity_st  = 1'b0;
        busy_st    = 1'b0;

        dir_tab = '{
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_SILENT, 64'd0},
            '{FUNC_START, 64'd0, 32'd0, 64'd0, ROW_FIXED, 64'd0},
            '{FUNC_START, '1, 32'd0, '1, ROW_MODEL, 64'd0},
            '{FUNC_START, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 64'd0, ROW_SILENT, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h8000_0000_0000_0001, ROW_SILENT, 64'd0},
            '{FUNC_START, 64'd1, 32'd3, 64'd0, ROW_SILENT, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  '1, '1, 64'h1234_5678_9ABC_DEF0, ROW_SILENT, 64'd0},
            '{FUNC_START, '1, 32'd8, 64'd0, ROW_SILENT, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_MODEL, 64'd0},
            '{FUNC_START, '1, 32'h8000_0000, '1, ROW_SILENT, 64'd0},
            '{FUNC_START, 64'h8000_0000_0000_0000, 32'd1, 64'd0, ROW_SILENT, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_MODEL, 64'd0},
            '{FUNC_START, 64'h5A5A_0F0F_3C3C_9696, 32'd79, 64'd0, ROW_SILENT, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h0706_0504_0302_0100, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h0F0E_0D0C_0B0A_0908, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'd0, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h5555_5555_5555_5555, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h8000_0000_0000_0000, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'h0000_0000_0000_0001, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, 64'hFEDC_BA98_7654_3210, ROW_MODEL, 64'd0},
            '{FUNC_DATA,  64'd0, 32'd0, '1, ROW_MODEL, 64'd0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            maybe_gap();
            put_req(dir_tab[i].func, dir_tab[i].seed, dir_tab[i].len, dir_tab[i].word,
                    dir_tab[i].kind, dir_tab[i].want);
        end

        base_items = n_items;
        while (n_items - base_items < RANDOM_ITEMS) begin
            tail_on = (n_items - base_items >= RANDOM_ITEMS - TAIL_ITEMS);
            pick = $urandom_range(0, 99);
            // stray data request while idle
            if (pick < 5) begin
                maybe_gap();
                put_req(FUNC_DATA, rnd64(), $urandom, rnd64(), ROW_MODEL, '0);
            end
            // message cut short by the next start
            if (pick >= 5 && pick < 17) begin
                maybe_gap();
                put_req(FUNC_START, rnd64(), $urandom, rnd64(), ROW_MODEL, '0);
                nw = $urandom_range(0, 5);
                repeat (nw) begin
                    maybe_gap();
                    put_req(FUNC_DATA, rnd64(), $urandom, rnd64(), ROW_MODEL, '0);
                end
            end
            case ($urandom_range(0, 9))
                0:       ln = 32'd0;
                1, 2, 3, 4: ln = $urandom_range(1, 31);
                5, 6, 7: ln = $urandom_range(32, 100);
                8:       ln = $urandom_range(101, 300);
                default: ln = $urandom_range(1, 16) * 8;
            endcase
            maybe_gap();
            put_req(FUNC_START, rnd64(), ln, rnd64(), ROW_MODEL, '0);
            nw = (ln + 7) / 8;
            repeat (nw) begin
                maybe_gap();
                put_req(FUNC_DATA, rnd64(), $urandom, rnd64(), ROW_MODEL, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d hashed requests incl. %0d starts, %0d digests compared",
                 n_items, n_starts, n_digests);
        if (n_err == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/xrh_pkg.sv
rtl/core/xrh_if.sv
rtl/core/xrh_front.sv
rtl/core/xrh_queue.sv
rtl/core/xrh_mul.sv
rtl/core/xrh_back.sv
rtl/core/xor_rotate_mixed_lane_hash64_unit.sv
tb/sv/tb.sv
